// ===== hw/rtl/svacc_pkg.sv =====
// Package for the spectral vector accumulator: payload and command types,
// register indexes, reset values and field widths. No dependencies.
`default_nettype none

package svacc_pkg;

	// Field widths fixed by the interface
	localparam int unsigned TS_W      = 40;
	localparam int unsigned SPEC_W    = 4;
	localparam int unsigned CH_W      = 10;
	localparam int unsigned SMP_W     = 8;
	localparam int unsigned OUT_SUM_W = 32;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 40;
	localparam int unsigned NCH_REG_W  = 11;
	localparam int unsigned NSPEC_W    = 5;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPECTRA_PER_HEAP = 2'd2;

	localparam logic [TS_W-1:0]      RST_WINDOW_LENGTH    = 40'd1048576;
	localparam logic [NCH_REG_W-1:0] RST_CHANNELS_IN_USE  = 11'd1024;
	localparam logic [NSPEC_W-1:0]   RST_SPECTRA_PER_HEAP = 5'd4;

	// Most spectra a heap may carry
	localparam logic [NSPEC_W-1:0] SPEC_MAX = 5'd16;

	// Command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;

	typedef struct packed {
		logic [TS_W-1:0]         heap_timestamp;
		logic [SPEC_W-1:0]       spectrum_index;
		logic [CH_W-1:0]         channel;
		logic signed [SMP_W-1:0] sample;
	} in_beat_t;

	typedef struct packed {
		logic [CH_W-1:0]             out_channel;
		logic signed [OUT_SUM_W-1:0] integrated_sum;
		logic [TS_W-1:0]             closing_timestamp;
		logic                        last_channel;
	} out_beat_t;

	// Classified sample handed from front to back
	typedef struct packed {
		logic [CH_W-1:0]         ch;
		logic signed [SMP_W-1:0] sample;
		logic [TS_W-1:0]         ts;
		logic                    emit;
		logic                    last;
	} cmd_t;

	// Queue occupancy seen by the front
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/svacc_front.sv =====
// Front end of the spectral vector accumulator: configuration registers,
// window tracking and classification of each sample. Uses svacc_pkg.
`default_nettype none

module svacc_front #(
	parameter int unsigned MAX_CHANNELS = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wen,
	input  wire logic [svacc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [svacc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire svacc_pkg::in_beat_t                in_data,
	input  wire svacc_pkg::qstat_t                  qstat,
	input  wire logic                               clr_busy,
	output logic                                    push,
	output svacc_pkg::cmd_t                         cmd
);

	localparam int unsigned NW = $clog2(MAX_CHANNELS + 1);
	localparam int unsigned CW = (NW > svacc_pkg::NCH_REG_W) ? NW : svacc_pkg::NCH_REG_W;

	logic [svacc_pkg::TS_W-1:0]      wl_q;
	logic [svacc_pkg::NCH_REG_W-1:0] nch_q;
	logic [svacc_pkg::NSPEC_W-1:0]   nspec_q;
	logic                            win_open_q;
	logic [svacc_pkg::TS_W-1:0]      win_start_q;

	logic [CW-1:0]                   nch_x;
	logic [CW-1:0]                   nch_eff;
	logic [CW-1:0]                   ch_x;
	logic [svacc_pkg::NSPEC_W-1:0]   nspec_eff;
	logic [svacc_pkg::TS_W-1:0]      start;
	logic [svacc_pkg::TS_W-1:0]      elapsed;
	logic                            in_use;
	logic                            spec_last;
	logic                            emit;
	logic                            last;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q    <= svacc_pkg::RST_WINDOW_LENGTH;
			nch_q   <= svacc_pkg::RST_CHANNELS_IN_USE;
			nspec_q <= svacc_pkg::RST_SPECTRA_PER_HEAP;
		end else if (cfg_wen) begin
			case (cfg_idx)
				svacc_pkg::REG_WINDOW_LENGTH: begin
					wl_q <= cfg_wdata[svacc_pkg::TS_W-1:0];
				end
				svacc_pkg::REG_CHANNELS_IN_USE: begin
					nch_q <= cfg_wdata[svacc_pkg::NCH_REG_W-1:0];
				end
				svacc_pkg::REG_SPECTRA_PER_HEAP: begin
					nspec_q <= cfg_wdata[svacc_pkg::NSPEC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp channel and spectrum counts into their usable ranges
	always_comb begin
		nch_x = CW'(nch_q);
		if (nch_x == '0) begin
			nch_eff = CW'(1);
		end else if (nch_x > CW'(MAX_CHANNELS)) begin
			nch_eff = CW'(MAX_CHANNELS);
		end else begin
			nch_eff = nch_x;
		end
		if (nspec_q == '0) begin
			nspec_eff = svacc_pkg::NSPEC_W'(1);
		end else if (nspec_q > svacc_pkg::SPEC_MAX) begin
			nspec_eff = svacc_pkg::SPEC_MAX;
		end else begin
			nspec_eff = nspec_q;
		end
	end

	// Classify the sample: in use, closes the window, last channel
	always_comb begin
		ch_x      = CW'(in_data.channel);
		in_use    = ch_x < nch_eff;
		last      = ch_x == (nch_eff - CW'(1));
		spec_last = svacc_pkg::NSPEC_W'(in_data.spectrum_index) ==
			(nspec_eff - svacc_pkg::NSPEC_W'(1));
		start     = win_open_q ? win_start_q : in_data.heap_timestamp;
		elapsed   = in_data.heap_timestamp - start;
		emit      = spec_last && !(elapsed < wl_q);
	end

	assign in_ready = !qstat.full && !clr_busy;
	assign push     = in_valid && in_ready && in_use;

	always_comb begin
		cmd.ch     = in_data.channel;
		cmd.sample = in_data.sample;
		cmd.ts     = in_data.heap_timestamp;
		cmd.emit   = emit;
		cmd.last   = last;
	end

	// Open the window on the first sample, restart it after the last channel emits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_open_q  <= 1'b0;
			win_start_q <= '0;
		end else if (push) begin
			win_open_q <= 1'b1;
			if (!win_open_q || (emit && last)) begin
				win_start_q <= in_data.heap_timestamp;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/svacc_queue.sv =====
// Short command queue between the front and the back of the accumulator.
// Uses svacc_pkg for the command and status types.
`default_nettype none

module svacc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire svacc_pkg::cmd_t   push_cmd,
	output svacc_pkg::qstat_t      qstat,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output svacc_pkg::cmd_t        pop_cmd
);

	svacc_pkg::cmd_t                 slots_q [svacc_pkg::QUEUE_DEPTH];
	logic [svacc_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [svacc_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [svacc_pkg::QPTR_W:0]      count_q;
	logic                            pop;

	assign qstat.full  = count_q == (svacc_pkg::QPTR_W + 1)'(svacc_pkg::QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign pop_valid   = !qstat.empty;
	assign pop         = pop_valid && pop_ready;
	assign pop_cmd     = slots_q[rd_ptr_q];

	// Store a beat at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + svacc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + svacc_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (svacc_pkg::QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (svacc_pkg::QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/svacc_back.sv =====
// Back end of the accumulator: per-channel sum memory with clearing pass,
// read-modify-write pipeline with bypass, and the result register. Uses svacc_pkg.
`default_nettype none

module svacc_back #(
	parameter int unsigned MAX_CHANNELS = 1024,
	parameter int unsigned SUM_WIDTH    = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_ready,
	input  wire svacc_pkg::cmd_t       cmd,
	output logic                       clr_busy,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output svacc_pkg::out_beat_t       out_data
);

	localparam int unsigned AW    = $clog2(MAX_CHANNELS);
	localparam int unsigned EXT_W = (SUM_WIDTH > svacc_pkg::OUT_SUM_W) ?
		SUM_WIDTH : svacc_pkg::OUT_SUM_W;

	logic signed [SUM_WIDTH-1:0] sums_mem [MAX_CHANNELS];

	logic                        clr_busy_q;
	logic [AW-1:0]               clr_addr_q;

	logic                        vld_s1;
	svacc_pkg::cmd_t             cmd_s1;
	logic signed [SUM_WIDTH-1:0] rd_s1;

	logic                        fwd_vld_q;
	logic [svacc_pkg::CH_W-1:0]  fwd_ch_q;
	logic signed [SUM_WIDTH-1:0] fwd_val_q;

	logic                        out_valid_q;
	svacc_pkg::out_beat_t        out_data_q;

	logic                        pop;
	logic                        fire_s1;
	logic signed [SUM_WIDTH-1:0] old_sum;
	logic signed [SUM_WIDTH:0]   sum_wide;
	logic signed [SUM_WIDTH-1:0] new_sum;
	logic signed [SUM_WIDTH-1:0] wr_val;
	logic signed [EXT_W-1:0]     sum_ext;

	assign clr_busy  = clr_busy_q;
	assign fire_s1   = vld_s1 && !(cmd_s1.emit && out_valid_q && !out_ready);
	assign cmd_ready = !clr_busy_q && (!vld_s1 || fire_s1);
	assign pop       = cmd_valid && cmd_ready;

	// Sweep the sum memory to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_CHANNELS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Sum memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			sums_mem[clr_addr_q] <= '0;
		end else if (fire_s1) begin
			sums_mem[AW'(cmd_s1.ch)] <= wr_val;
		end
		if (pop) begin
			rd_s1 <= sums_mem[AW'(cmd.ch)];
		end
	end

	// Hold the command beside its read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pop) begin
			vld_s1 <= 1'b1;
		end else if (fire_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= cmd;
		end
	end

	// Bypass the write that landed on the same edge as the read
	assign old_sum = (fwd_vld_q && (fwd_ch_q == cmd_s1.ch)) ? fwd_val_q : rd_s1;

	// Saturating add of the sample
	always_comb begin
		sum_wide = (SUM_WIDTH + 1)'(old_sum) + (SUM_WIDTH + 1)'(cmd_s1.sample);
		if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
			new_sum = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH - 1){1'b0}}} :
				{1'b0, {(SUM_WIDTH - 1){1'b1}}};
		end else begin
			new_sum = sum_wide[SUM_WIDTH-1:0];
		end
		wr_val  = cmd_s1.emit ? '0 : new_sum;
		sum_ext = EXT_W'(new_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (fire_s1) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			fwd_ch_q  <= cmd_s1.ch;
			fwd_val_q <= wr_val;
		end
	end

	// Result register: load on an emitting beat, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && cmd_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && cmd_s1.emit) begin
			out_data_q.out_channel       <= cmd_s1.ch;
			out_data_q.integrated_sum    <= sum_ext[svacc_pkg::OUT_SUM_W-1:0];
			out_data_q.closing_timestamp <= cmd_s1.ts;
			out_data_q.last_channel      <= cmd_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/spectral_vector_accumulator_unit.sv =====
// Top level of the spectral vector accumulator: front classifier, command
// queue and accumulating back end. Uses svacc_pkg, svacc_front, svacc_queue, svacc_back.
//
//   channel  signals                          beat
//   -------  -------------------------------  ----------------------------
//   in       in_valid / in_ready / in_data     one sample (in_beat_t)
//   out      out_valid / out_ready / out_data  one channel sum (out_beat_t)
//   cfg      cfg_wen / cfg_idx / cfg_wdata     one register write, no wait
//
// One sample per cycle sustained while in_ready is high; with the queue empty an accepted
// sample passes the queue, then the memory read stage, before it loads the result register.
// After reset the sum memory is cleared one entry per cycle with in_ready low;
// configuration writes are taken throughout. Once the clearing pass is over,
// only a result that cannot leave stalls the back; the four-entry queue then
// fills and in_ready drops.
`default_nettype none

module spectral_vector_accumulator_unit #(
	parameter int unsigned MAX_CHANNELS = 1024,
	parameter int unsigned SUM_WIDTH    = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wen,
	input  wire logic [svacc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [svacc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire svacc_pkg::in_beat_t                in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output svacc_pkg::out_beat_t                    out_data
);

	svacc_pkg::qstat_t qstat;
	svacc_pkg::cmd_t   push_cmd;
	svacc_pkg::cmd_t   pop_cmd;
	logic              push;
	logic              pop_valid;
	logic              pop_ready;
	logic              clr_busy;

	svacc_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.qstat    (qstat),
		.clr_busy (clr_busy),
		.push     (push),
		.cmd      (push_cmd)
	);

	svacc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.qstat    (qstat),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_cmd  (pop_cmd)
	);

	svacc_back #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.SUM_WIDTH   (SUM_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(pop_valid),
		.cmd_ready(pop_ready),
		.cmd      (pop_cmd),
		.clr_busy (clr_busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

`ifndef NO_ASSERTIONS
	// No sample enters while the sum memory is being cleared
	assert property (@(posedge clk) disable iff (!arst_n) clr_busy |-> !in_ready)
		else $error("sample accepted during clearing pass");

	// No result can exist before the clearing pass ends
	assert property (@(posedge clk) disable iff (!arst_n) clr_busy |-> !out_valid)
		else $error("result produced during clearing pass");

	// The clearing pass runs once after reset and never restarts
	assert property (@(posedge clk) disable iff (!arst_n) !clr_busy |=> !clr_busy)
		else $error("clearing pass restarted");

	// The back never takes a beat while the queue is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |-> !qstat.empty)
		else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/svacc_sum_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the spectral vector accumulator: shadows the register writes,
// integrates every accepted sample beat and compares each emitted channel sum.
// Depends on svacc_pkg.

module svacc_sum_checker #(
	parameter int unsigned MAX_CHANNELS = 1024,
	parameter int unsigned SUM_WIDTH    = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [svacc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [svacc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  svacc_pkg::in_beat_t               in_data,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  svacc_pkg::out_beat_t              out_data,
	output int                                n_errors,
	output int                                n_pending,
	output int                                n_checked
);
	import svacc_pkg::*;

	localparam longint SUM_HI = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
	localparam longint SUM_LO = -SUM_HI - 1;

	// Shadow registers and integration state
	logic [TS_W-1:0]      win_len;
	logic [NCH_REG_W-1:0] nch_reg;
	logic [NSPEC_W-1:0]   nspec_reg;
	longint               chan_sum [MAX_CHANNELS];
	logic [TS_W-1:0]      win_start;
	bit                   win_open;

	out_beat_t sums_due [$];
	out_beat_t head;
	int        n_bad  = 0;
	int        n_seen = 0;

	assign n_errors  = n_bad;
	assign n_checked = n_seen;

	// Add one sample into its channel and queue the sum it closes, if any
	task automatic integrate_sample(input in_beat_t b);
		int unsigned     nch;
		int unsigned     nspec;
		longint          acc;
		logic [TS_W-1:0] elapsed;
		out_beat_t       r;
		nch   = (nch_reg == 0) ? 1 : (nch_reg > MAX_CHANNELS) ? MAX_CHANNELS : nch_reg;
		nspec = (nspec_reg == 0) ? 1 : (nspec_reg > SPEC_MAX) ? SPEC_MAX : nspec_reg;
		// drop channels outside the ones in use
		if (b.channel >= nch)
			return;
		if (!win_open) begin
			win_open  = 1'b1;
			win_start = b.heap_timestamp;
		end
		acc = chan_sum[b.channel] + longint'($signed(b.sample));
		if (acc > SUM_HI)
			acc = SUM_HI;
		else if (acc < SUM_LO)
			acc = SUM_LO;
		chan_sum[b.channel] = acc;
		// only the heap's last spectrum can close the window
		if (b.spectrum_index != nspec - 1)
			return;
		elapsed = b.heap_timestamp - win_start;
		if (elapsed < win_len)
			return;
		r.out_channel       = b.channel;
		r.integrated_sum    = acc[OUT_SUM_W-1:0];
		r.closing_timestamp = b.heap_timestamp;
		r.last_channel      = (b.channel == nch - 1);
		sums_due.push_back(r);
		chan_sum[b.channel] = 0;
		if (b.channel == nch - 1)
			win_start = b.heap_timestamp;
	endtask

	// Track register writes, check result beats, then predict from sample beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len   = RST_WINDOW_LENGTH;
			nch_reg   = RST_CHANNELS_IN_USE;
			nspec_reg = RST_SPECTRA_PER_HEAP;
			foreach (chan_sum[i])
				chan_sum[i] = 0;
			win_start = '0;
			win_open  = 1'b0;
			sums_due.delete();
			n_pending <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					REG_WINDOW_LENGTH:    win_len   = cfg_wdata[TS_W-1:0];
					REG_CHANNELS_IN_USE:  nch_reg   = cfg_wdata[NCH_REG_W-1:0];
					REG_SPECTRA_PER_HEAP: nspec_reg = cfg_wdata[NSPEC_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (sums_due.size() == 0) begin
					$error("unexpected sum beat: channel %0d sum %0d",
						out_data.out_channel, out_data.integrated_sum);
					n_bad++;
				end else begin
					head = sums_due.pop_front();
					n_seen++;
					if (out_data.out_channel !== head.out_channel) begin
						$error("out_channel expected %0d actual %0d",
							head.out_channel, out_data.out_channel);
						n_bad++;
					end
					if (out_data.integrated_sum !== head.integrated_sum) begin
						$error("integrated_sum expected %0d actual %0d",
							head.integrated_sum, out_data.integrated_sum);
						n_bad++;
					end
					if (out_data.closing_timestamp !== head.closing_timestamp) begin
						$error("closing_timestamp expected %0d actual %0d",
							head.closing_timestamp, out_data.closing_timestamp);
						n_bad++;
					end
					if (out_data.last_channel !== head.last_channel) begin
						$error("last_channel expected %0d actual %0d",
							head.last_channel, out_data.last_channel);
						n_bad++;
					end
				end
			end
			if (in_valid && in_ready)
				integrate_sample(in_data);
			n_pending <= sums_due.size();
		end
	end

endmodule

// ===== tb/sv/spectral_vector_accumulator_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the spectral vector accumulator: clock, reset, register
// settings, sample stimulus and verdict. Depends on svacc_pkg,
// spectral_vector_accumulator_unit and svacc_sum_checker.

module spectral_vector_accumulator_unit_test;
	import svacc_pkg::*;

	localparam int unsigned     MAX_CH      = 1024;
	localparam int unsigned     SUM_W       = 32;
	localparam int              N_SAMPLES   = 2000;
	localparam int              QUIET_TAIL  = 300;
	localparam int              SETTLE      = 12;
	localparam int unsigned     STALL_LIMIT = 6000;
	localparam logic [TS_W-1:0] TS_MAX      = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	in_beat_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_beat_t             out_data;
	int                    n_errors;
	int                    n_pending;
	int                    n_checked;

	bit              gaps_on;
	bit              stalls_on;
	int unsigned     nch_now;
	int unsigned     nspec_now;
	logic [TS_W-1:0] heap_ts;
	int              n_used;
	int              n_ignored;
	int              n_settings;
	int unsigned     idle_run;

	spectral_vector_accumulator_unit #(
		.MAX_CHANNELS(MAX_CH),
		.SUM_WIDTH   (SUM_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	svacc_sum_checker #(
		.MAX_CHANNELS(MAX_CH),
		.SUM_WIDTH   (SUM_W)
	) u_sum_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.n_errors (n_errors),
		.n_pending(n_pending),
		.n_checked(n_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Drain the result channel, stalling in random bursts when enabled
	initial begin
		out_ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (stalls_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Abort if no beat moves on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= STALL_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles", idle_run);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offer one sample beat and hold it until taken; valid stays high afterwards.
	// Stop idling on both sides once the run reaches its quiet tail.
	task automatic send_sample(input logic [TS_W-1:0] ts, input int unsigned spec,
	                           input int unsigned ch, input int smp);
		in_beat_t b;
		b.heap_timestamp = ts;
		b.spectrum_index = SPEC_W'(spec);
		b.channel        = CH_W'(ch);
		b.sample         = SMP_W'(smp);
		if (N_SAMPLES - n_used <= QUIET_TAIL) begin
			gaps_on   = 1'b0;
			stalls_on = 1'b0;
		end
		if (b.channel < nch_now)
			n_used++;
		else
			n_ignored++;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid and wait for every queued sum plus the pipeline's own latency
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (n_pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all three registers back to back and note the effective values
	task automatic apply_settings(input logic [TS_W-1:0] wl, input logic [NCH_REG_W-1:0] nch,
	                              input logic [NSPEC_W-1:0] nspec);
		cfg_wen   <= 1'b1;
		cfg_idx   <= REG_WINDOW_LENGTH;
		cfg_wdata <= CFG_DATA_W'(wl);
		@(posedge clk);
		cfg_idx   <= REG_CHANNELS_IN_USE;
		cfg_wdata <= CFG_DATA_W'(nch);
		@(posedge clk);
		cfg_idx   <= REG_SPECTRA_PER_HEAP;
		cfg_wdata <= CFG_DATA_W'(nspec);
		@(posedge clk);
		cfg_wen   <= 1'b0;
		nch_now   = (nch == 0) ? 1 : (nch > MAX_CH) ? MAX_CH : nch;
		nspec_now = (nspec == 0) ? 1 : (nspec > SPEC_MAX) ? SPEC_MAX : nspec;
		n_settings++;
	endtask

	// Step the heap timestamp: mostly forwards, sometimes back, now and then anywhere
	function automatic logic [TS_W-1:0] next_heap_ts(input logic [TS_W-1:0] ts);
		case ($urandom_range(0, 19))
			0:       return TS_W'({$urandom, $urandom});
			1, 2:    return ts - TS_W'($urandom_range(1, 64));
			default: return ts + TS_W'($urandom_range(0, 24));
		endcase
	endfunction

	initial begin : stimulus
		logic [TS_W-1:0]      wl;
		logic [NCH_REG_W-1:0] nch;
		logic [NSPEC_W-1:0]   nsp;
		bit                   sparse;

		arst_n    <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_idx   <= '0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gaps_on   = 1'b1;
		stalls_on = 1'b1;

		// Zero registers act as one channel, one spectrum; zero window closes at once
		apply_settings('0, '0, '0);
		send_sample(40'd5, 0, 1, 127);
		send_sample(TS_MAX, 0, 0, -128);
		send_sample(40'd3, 15, 0, 127);
		send_sample(40'd0, 0, 0, 127);
		send_sample(40'd0, 0, 1023, 0);
		settle();

		// Oversized registers clamp; widest window only closes on a full wrap
		apply_settings(TS_MAX, 11'd2047, 5'd31);
		send_sample(40'd9, 15, 1023, -1);
		send_sample(TS_MAX, 15, 1023, -1);
		send_sample(TS_MAX - 1, 15, 512, 100);
		send_sample(40'd0, 0, 0, 1);
		send_sample(40'd1, 14, 1, -128);
		settle();

		// Shortest nonzero window with all channels and sixteen spectra
		apply_settings(40'd1, 11'd1024, 5'd16);
		send_sample(40'd0, 15, 0, -5);
		send_sample(40'd0, 15, 1, 5);
		send_sample(40'd0, 15, 1023, 0);
		send_sample(40'd0, 15, 2, 7);
		settle();

		// Reset-sized window, two channels, single spectrum
		apply_settings(RST_WINDOW_LENGTH, 11'd2, 5'd1);
		send_sample(40'd1048575, 0, 0, 42);
		send_sample(40'd1048576, 0, 1, -77);
		send_sample(40'd1048576, 0, 2, 3);
		send_sample(40'd1048576, 0, 0, -1);

		// Random phases of heaps under random settings
		heap_ts = 40'd1048576;
		while (n_used < N_SAMPLES) begin
			settle();
			if (N_SAMPLES - n_used <= QUIET_TAIL) begin
				gaps_on   = 1'b0;
				stalls_on = 1'b0;
			end else begin
				gaps_on   = ($urandom_range(0, 3) != 0);
				stalls_on = ($urandom_range(0, 3) != 0);
			end
			case ($urandom_range(0, 9))
				0:       wl = '0;
				1:       wl = TS_W'({$urandom, $urandom});
				2:       wl = TS_MAX;
				default: wl = TS_W'($urandom_range(1, 40));
			endcase
			sparse = ($urandom_range(0, 7) == 0);
			if (sparse)
				nch = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
			else
				nch = NCH_REG_W'($urandom_range(0, 12));
			if ($urandom_range(0, 9) == 0)
				nsp = NSPEC_W'($urandom_range(16, 31));
			else
				nsp = NSPEC_W'($urandom_range(0, 4));
			apply_settings(wl, nch, nsp);

			if (sparse) begin
				// Wide channel range: scattered beats, last channel and last spectrum favoured
				repeat (24) begin
					heap_ts = next_heap_ts(heap_ts);
					send_sample(heap_ts,
						$urandom_range(0, 1) ? nspec_now - 1 : $urandom_range(0, 15),
						$urandom_range(0, 3) == 0 ? nch_now - 1 : $urandom_range(0, nch_now - 1),
						$urandom_range(0, 255));
				end
			end else begin
				// Well-formed heaps with stray beats and the odd missing sample
				repeat ($urandom_range(2, 6)) begin
					heap_ts = next_heap_ts(heap_ts);
					for (int unsigned sp = 0; sp < nspec_now && n_used < N_SAMPLES; sp++) begin
						for (int unsigned c = 0; c < nch_now && n_used < N_SAMPLES; c++) begin
							if ($urandom_range(0, 15) == 0)
								send_sample(TS_W'({$urandom, $urandom}), $urandom_range(0, 15),
									$urandom_range(0, 1023), $urandom_range(0, 255));
							if ($urandom_range(0, 31) != 0)
								send_sample(heap_ts, sp, c, $urandom_range(0, 255));
						end
					end
				end
			end
		end

		settle();
		$display("Run covered %0d in-use and %0d out-of-use samples over %0d register settings,",
			n_used, n_ignored, n_settings);
		$display("with %0d channel sums compared field by field.", n_checked);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/svacc_pkg.sv
hw/rtl/svacc_front.sv
hw/rtl/svacc_queue.sv
hw/rtl/svacc_back.sv
hw/rtl/spectral_vector_accumulator_unit.sv
tb/sv/svacc_sum_checker.sv
tb/sv/spectral_vector_accumulator_unit_test.sv
